[sv/julian_day_to_calendar_date_top_macros.svh]
// Assertion macros for the day-number to calendar date converter.
// Used by julian_day_to_calendar_date_top; expects clk and rst in scope.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_TOP_MACROS_SVH

// Condition implies an expression in the same cycle.
`define JDC_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Condition implies an expression after the delay given by n.
`define JDC_ASSERT_DELAY(label, cond, n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (expr)) \
    else $error(msg);

`endif

[sv/jdcal_pkg.sv]
// Shared types, pipeline depths and the month-length table of the converter.
// No dependencies; imported by every module of the block.
package jdcal_pkg;

  // Stage counts of the date and clock sections; the split section has three.
  localparam int SPLIT_STAGES = 3;
  localparam int DATE_STAGES  = 12;
  localparam int CLOCK_STAGES = 4;
  localparam int LATENCY      = SPLIT_STAGES + DATE_STAGES;

  typedef struct packed {
    logic signed [38:0] whole_seconds;
    logic [19:0]        micro_seconds;
  } jd_in_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [19:0]        micro_second;
  } jd_out_t;

  // Day number and second of day after the split section.
  typedef struct packed {
    logic [22:0] jdn;
    logic [16:0] sod;
    logic [19:0] micro;
  } jd_day_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } jd_date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
  } jd_time_t;

  // Whole days in the first e months of the shifted year, floor(30.6001 * e).
  function automatic logic [8:0] month_span(input logic [3:0] e);
    logic [8:0] span;
    case (e)
      4'd0:    span = 9'd0;
      4'd1:    span = 9'd30;
      4'd2:    span = 9'd61;
      4'd3:    span = 9'd91;
      4'd4:    span = 9'd122;
      4'd5:    span = 9'd153;
      4'd6:    span = 9'd183;
      4'd7:    span = 9'd214;
      4'd8:    span = 9'd244;
      4'd9:    span = 9'd275;
      4'd10:   span = 9'd306;
      4'd11:   span = 9'd336;
      4'd12:   span = 9'd367;
      4'd13:   span = 9'd397;
      4'd14:   span = 9'd428;
      4'd15:   span = 9'd459;
      default: span = 9'd0;
    endcase
    return span;
  endfunction

endpackage

[sv/jdcal_day_split.sv]
// Splits the noon-shifted time into a day number and a second of day.
// Depends on jdcal_pkg; three register stages.
module jdcal_day_split import jdcal_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  jd_in_t  in_word,
  output logic    out_valid,
  output jd_day_t out_word
);

  localparam logic signed [38:0] SecLow  = -39'sd211813488000;
  localparam logic signed [38:0] SecHigh = 39'sd211813487999;
  // Noon shift plus the day number of the epoch in seconds keeps the sum positive.
  localparam logic [39:0] Offset = 40'd211813531200;
  localparam int RecipShift = 41;
  localparam logic [31:0] DayRecip = 32'((64'd1 << RecipShift) / 675);

  logic signed [38:0] secs_clamped;
  logic [39:0]        shifted;
  logic [63:0]        est_prod;
  logic [31:0]        est_back;
  logic [31:0]        est_diff;
  logic [10:0]        rem;
  logic               fix;
  logic [10:0]        rem_fixed;

  logic        s1_valid;
  logic [31:0] s1_scaled;
  logic [6:0]  s1_low;
  logic [19:0] s1_micro;
  logic        s2_valid;
  logic [22:0] s2_est;
  logic [31:0] s2_scaled;
  logic [6:0]  s2_low;
  logic [19:0] s2_micro;

  always_comb begin
    if (in_word.whole_seconds < SecLow) begin
      secs_clamped = SecLow;
    end else if (in_word.whole_seconds > SecHigh) begin
      secs_clamped = SecHigh;
    end else begin
      secs_clamped = in_word.whole_seconds;
    end
    shifted = {secs_clamped[38], secs_clamped} + Offset;
  end

  // 86400 is 128 times 675: the low seven bits go straight to the second of day.
  assign est_prod  = 64'(s1_scaled) * 64'(DayRecip);
  assign est_back  = {9'b0, s2_est} * 32'd675;
  assign est_diff  = s2_scaled - est_back;
  assign rem       = est_diff[10:0];
  assign fix       = (rem >= 11'd675);
  assign rem_fixed = fix ? rem - 11'd675 : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
    s1_scaled <= shifted[38:7];
    s1_low    <= shifted[6:0];
    s1_micro  <= in_word.micro_seconds;
    s2_est    <= est_prod[63:41];
    s2_scaled <= s1_scaled;
    s2_low    <= s1_low;
    s2_micro  <= s1_micro;
    out_word.jdn   <= s2_est + {22'b0, fix};
    out_word.sod   <= {rem_fixed[9:0], s2_low};
    out_word.micro <= s2_micro;
  end

endmodule

[sv/jdcal_date.sv]
// Calendar date from the day number, after Meeus, as a twelve-stage pipeline.
// Depends on jdcal_pkg for the result type and the month-length table.
module jdcal_date import jdcal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [22:0] jdn,
  output logic        out_valid,
  output jd_date_t    date_word
);

  localparam logic [13:0] AlphaRecip = 14'((64'd1 << 31) / 146097);
  localparam logic [14:0] CentRecip  = 15'((64'd1 << 27) / 7305);
  localparam logic [11:0] MonthRecip = 12'((64'd10000 << 16) / 306001);

  logic [DATE_STAGES-1:0] valid;

  logic signed [25:0] alpha_num;
  logic [25:0]        alpha_abs_full;
  logic [37:0]        alpha_prod;
  logic [23:0]        alpha_back;
  logic [23:0]        alpha_rem;
  logic               alpha_fix;
  logic [7:0]         alpha_abs;
  logic signed [7:0]  alpha_quarter;
  logic [23:0]        b_sum;
  logic [26:0]        cent_num;
  logic [41:0]        cent_prod;
  logic [26:0]        cent_back;
  logic [26:0]        cent_rem;
  logic               cent_fix;
  logic [24:0]        year_days;
  logic [22:0]        day_off;
  logic [20:0]        month_prod;
  logic [22:0]        month_scaled;
  logic [22:0]        month_back;
  logic [22:0]        month_rem;
  logic               month_fix;
  logic [3:0]         month_val;
  logic [8:0]         day_val;

  logic [23:0]        d1_mag;
  logic               d1_neg;
  logic [22:0]        d1_jdn;
  logic [6:0]         d2_est;
  logic [23:0]        d2_mag;
  logic               d2_neg;
  logic [22:0]        d2_jdn;
  logic signed [7:0]  d3_alpha;
  logic [22:0]        d3_jdn;
  logic [22:0]        d4_b;
  logic [26:0]        d5_num;
  logic [22:0]        d5_b;
  logic [13:0]        d6_est;
  logic [26:0]        d6_num;
  logic [22:0]        d6_b;
  logic [13:0]        d7_c;
  logic [22:0]        d7_b;
  logic [22:0]        d8_d;
  logic [13:0]        d8_c;
  logic [22:0]        d8_b;
  logic [8:0]         d9_bd;
  logic [13:0]        d9_c;
  logic [3:0]         d10_est;
  logic [8:0]         d10_bd;
  logic [13:0]        d10_c;
  logic [3:0]         d11_e;
  logic [8:0]         d11_bd;
  logic [13:0]        d11_c;

  // Each constant division is a reciprocal estimate that is at most one low,
  // followed a stage later by a single remainder check.
  assign alpha_num      = $signed({1'b0, jdn, 2'b00}) - 26'sd7468865;
  assign alpha_abs_full = alpha_num[25] ? 26'(-alpha_num) : 26'(alpha_num);
  assign alpha_prod     = 38'(d1_mag) * 38'(AlphaRecip);
  assign alpha_back     = {17'b0, d2_est} * 24'd146097;
  assign alpha_rem      = d2_mag - alpha_back;
  assign alpha_fix      = (alpha_rem >= 24'd146097);
  assign alpha_abs      = {1'b0, d2_est} + {7'b0, alpha_fix};

  // The quarter of alpha truncates towards zero, so negative values are biased.
  assign alpha_quarter = (d3_alpha + (d3_alpha[7] ? 8'sd3 : 8'sd0)) >>> 2;
  assign b_sum = {1'b0, d3_jdn} + 24'd1525 + {{16{d3_alpha[7]}}, d3_alpha}
               - {{16{alpha_quarter[7]}}, alpha_quarter};

  assign cent_num  = {d4_b, 4'b0} + {2'b0, d4_b, 2'b0} - 27'd2442;
  assign cent_prod = 42'(d5_num) * 42'(CentRecip);
  assign cent_back = {13'b0, d6_est} * 27'd7305;
  assign cent_rem  = d6_num - cent_back;
  assign cent_fix  = (cent_rem >= 27'd7305);

  assign year_days = {11'b0, d7_c} * 25'd1461;
  assign day_off   = d8_b - d8_d;

  assign month_prod   = {12'b0, d9_bd} * 21'(MonthRecip);
  assign month_scaled = {14'b0, d10_bd} * 23'd10000;
  assign month_back   = {19'b0, d10_est} * 23'd306001;
  assign month_rem    = month_scaled - month_back;
  assign month_fix    = (month_rem >= 23'd306001);

  assign month_val = (d11_e < 4'd14) ? d11_e - 4'd1 : d11_e - 4'd13;
  assign day_val   = d11_bd - month_span(d11_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DATE_STAGES-2:0], in_valid};
    end
    d1_mag   <= alpha_abs_full[23:0];
    d1_neg   <= alpha_num[25];
    d1_jdn   <= jdn;
    d2_est   <= alpha_prod[37:31];
    d2_mag   <= d1_mag;
    d2_neg   <= d1_neg;
    d2_jdn   <= d1_jdn;
    d3_alpha <= d2_neg ? $signed(-alpha_abs) : $signed(alpha_abs);
    d3_jdn   <= d2_jdn;
    d4_b     <= b_sum[22:0];
    d5_num   <= cent_num;
    d5_b     <= d4_b;
    d6_est   <= cent_prod[40:27];
    d6_num   <= d5_num;
    d6_b     <= d5_b;
    d7_c     <= d6_est + {13'b0, cent_fix};
    d7_b     <= d6_b;
    d8_d     <= year_days[24:2];
    d8_c     <= d7_c;
    d8_b     <= d7_b;
    d9_bd    <= day_off[8:0];
    d9_c     <= d8_c;
    d10_est  <= month_prod[19:16];
    d10_bd   <= d9_bd;
    d10_c    <= d9_c;
    d11_e    <= d10_est + {3'b0, month_fix};
    d11_bd   <= d10_bd;
    d11_c    <= d10_c;
    date_word.month <= month_val;
    date_word.day   <= day_val[4:0];
    if (month_val > 4'd2) begin
      date_word.year <= $signed({1'b0, d11_c}) - 15'sd4716;
    end else begin
      date_word.year <= $signed({1'b0, d11_c}) - 15'sd4715;
    end
  end

  assign out_valid = valid[DATE_STAGES-1];

endmodule

[sv/jdcal_clock.sv]
// Hour, minute and second from the second of day, delayed to meet the date.
// Depends on jdcal_pkg for the time type and the stage counts.
module jdcal_clock import jdcal_pkg::*; (
  input  logic        clk,
  input  logic [16:0] sod,
  input  logic [19:0] micro,
  output jd_time_t    time_word
);

  // The first entry of the line is the last arithmetic stage, so the line holds
  // one entry more than the gap between the two sections.
  localparam int Delay = DATE_STAGES - CLOCK_STAGES + 1;
  // Exact reciprocals: 3600 is 16 times 225 and 60 is 4 times 15.
  localparam logic [12:0] HourRecip = 13'(((64'd1 << 20) + 224) / 225);
  localparam logic [10:0] MinRecip  = 11'(((64'd1 << 14) + 14) / 15);

  logic [24:0] hour_prod;
  logic [16:0] hour_secs;
  logic [16:0] hour_rem;
  logic [20:0] min_prod;
  logic [11:0] min_secs;
  logic [11:0] sec_rem;

  logic [4:0]  c1_hour;
  logic [16:0] c1_sod;
  logic [19:0] c1_micro;
  logic [4:0]  c2_hour;
  logic [11:0] c2_rh;
  logic [19:0] c2_micro;
  logic [4:0]  c3_hour;
  logic [5:0]  c3_min;
  logic [11:0] c3_rh;
  logic [19:0] c3_micro;
  jd_time_t    line [Delay];

  assign hour_prod = {12'b0, sod[16:4]} * 25'(HourRecip);
  assign hour_secs = {12'b0, c1_hour} * 17'd3600;
  assign hour_rem  = c1_sod - hour_secs;
  assign min_prod  = {11'b0, c2_rh[11:2]} * 21'(MinRecip);
  assign min_secs  = {6'b0, c3_min} * 12'd60;
  assign sec_rem   = c3_rh - min_secs;

  always_ff @(posedge clk) begin
    c1_hour  <= hour_prod[24:20];
    c1_sod   <= sod;
    c1_micro <= micro;
    c2_hour  <= c1_hour;
    c2_rh    <= hour_rem[11:0];
    c2_micro <= c1_micro;
    c3_hour  <= c2_hour;
    c3_min   <= min_prod[19:14];
    c3_rh    <= c2_rh;
    c3_micro <= c2_micro;
    line[0].hour   <= c3_hour;
    line[0].minute <= c3_min;
    line[0].second <= sec_rem[5:0];
    line[0].micro  <= c3_micro;
    for (int i = 1; i < Delay; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign time_word = line[Delay-1];

endmodule

[sv/julian_day_to_calendar_date_top.sv]
// Top level of the J2000 seconds to Gregorian date and time converter.
// Depends on jdcal_pkg, jdcal_day_split, jdcal_date, jdcal_clock and the macros header.
//
//   channel   ports                  handshake
//   input     start, busy, item      word taken when start is high and busy low
//   output    done, result           word valid for the one cycle done is high
//
// One word is taken every cycle while busy is low; each result passes through
// three stages of day split and twelve of date arithmetic before it appears.
// Reset is synchronous: it empties the pipeline and holds busy high until the
// cycle after it is released. The receiver cannot stall, so the pipeline
// advances on every clock and no word is ever held back or repeated.
`include "julian_day_to_calendar_date_top_macros.svh"

module julian_day_to_calendar_date_top import jdcal_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  jd_in_t  item,
  output logic    done,
  output jd_out_t result
);

  logic     accept;
  logic     split_valid;
  jd_day_t  split_word;
  jd_date_t date_word;
  jd_time_t time_word;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  jdcal_day_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_word   (item),
    .out_valid (split_valid),
    .out_word  (split_word)
  );

  jdcal_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .jdn       (split_word.jdn),
    .out_valid (done),
    .date_word (date_word)
  );

  jdcal_clock u_clock (
    .clk       (clk),
    .sod       (split_word.sod),
    .micro     (split_word.micro),
    .time_word (time_word)
  );

  always_comb begin
    result.year         = date_word.year;
    result.month        = date_word.month;
    result.day          = date_word.day;
    result.hour         = time_word.hour;
    result.minute       = time_word.minute;
    result.second       = time_word.second;
    result.micro_second = time_word.micro;
  end

  // Every taken word comes out as a result with its fraction intact, and its fields stay in range.
  `JDC_ASSERT_DELAY(a_latency, accept, LATENCY, done, "result missing after latency")
  `JDC_ASSERT_IMPL(a_micro, done, result.micro_second == $past(item.micro_seconds, LATENCY), "fraction not aligned with date")
  `JDC_ASSERT_IMPL(a_range, done, result.month >= 4'd1 && result.month <= 4'd12 && result.day >= 5'd1 && result.hour <= 5'd23 && result.minute <= 6'd59 && result.second <= 6'd59, "field out of range")

endmodule
